// ----- src/y2r_pkg.sv -----
// ----------------------------------------------------------------------------
// y2r_pkg
// Shared types, widths and helpers for the 4:2:0 block color converter.
// ----------------------------------------------------------------------------
`default_nettype none

package y2r_pkg;

    localparam int SAMPLE_W = 8;
    localparam int COEF_W   = 16;
    localparam int CFG_W    = 3 * COEF_W;
    localparam int PROD_W   = 2 * COEF_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int FRAC_W   = 8;
    localparam int NUM_CH   = 3;
    localparam int NUM_PIX  = 4;
    localparam int IDX_W    = 2;

    // field positions inside a packed 48-bit register
    localparam int FLD_Y = 0;
    localparam int FLD_U = 1;
    localparam int FLD_V = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_CH0_ROW  = 2'd0,
        REG_CH1_ROW  = 2'd1,
        REG_CH2_ROW  = 2'd2,
        REG_OFFSETS  = 2'd3
    } reg_idx_t;

    typedef logic [CFG_W-1:0]           cfg_word_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic [SAMPLE_W-1:0]        pix_t;

    // stage advance strobes handed to the per-pixel datapath
    typedef struct packed {
        logic en_prod;
        logic en_out;
    } stage_ctl_t;

    function automatic coef_t field16(input cfg_word_t word, input int k);
        field16 = coef_t'(word[COEF_W*k +: COEF_W]);
    endfunction

    // floor shift, then clamp to 0..255
    function automatic pix_t clamp_sum(input sum_t s);
        pix_t res;
        if (s[SUM_W-1])
        begin
            res = '0;
        end
        else if (|s[SUM_W-2:FRAC_W+SAMPLE_W])
        begin
            res = '1;
        end
        else
        begin
            res = s[FRAC_W+SAMPLE_W-1:FRAC_W];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- src/y2r_pixel.sv -----
// ----------------------------------------------------------------------------
// y2r_pixel
// Three output channels of one pixel: luma products, then sum, shift, clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module y2r_pixel (
    input  wire logic                                        clk,
    input  wire y2r_pkg::stage_ctl_t                         ctl,
    input  wire y2r_pkg::coef_t                              y_diff,
    input  wire y2r_pkg::cfg_word_t [y2r_pkg::NUM_CH-1:0]    rows,
    input  wire y2r_pkg::prod_t     [y2r_pkg::NUM_CH-1:0]    u_prod,
    input  wire y2r_pkg::prod_t     [y2r_pkg::NUM_CH-1:0]    v_prod,
    output      y2r_pkg::pix_t      [y2r_pkg::NUM_CH-1:0]    ch
);

    y2r_pkg::prod_t [y2r_pkg::NUM_CH-1:0] y_prod_reg;
    y2r_pkg::prod_t [y2r_pkg::NUM_CH-1:0] y_prod_next;
    y2r_pkg::pix_t  [y2r_pkg::NUM_CH-1:0] ch_reg;
    y2r_pkg::pix_t  [y2r_pkg::NUM_CH-1:0] ch_next;

    always_comb
    begin
        for (int c = 0; c < y2r_pkg::NUM_CH; c++)
        begin
            y_prod_next[c] = y2r_pkg::field16(rows[c], y2r_pkg::FLD_Y) * y_diff;
        end
    end

    always_comb
    begin
        for (int c = 0; c < y2r_pkg::NUM_CH; c++)
        begin
            ch_next[c] = y2r_pkg::clamp_sum(
                {{2{y_prod_reg[c][y2r_pkg::PROD_W-1]}}, y_prod_reg[c]} +
                {{2{u_prod[c][y2r_pkg::PROD_W-1]}}, u_prod[c]} +
                {{2{v_prod[c][y2r_pkg::PROD_W-1]}}, v_prod[c]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_prod)
        begin
            y_prod_reg <= y_prod_next;
        end
        if (ctl.en_out)
        begin
            ch_reg <= ch_next;
        end
    end

    assign ch = ch_reg;

endmodule

`default_nettype wire

// ----- src/yuv420_to_rgb_block.sv -----
// ----------------------------------------------------------------------------
// yuv420_to_rgb_block
// Color conversion of one 2x2 block of a 4:2:0 picture into 4 pixels x 3 ch.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_stall    four luma, chroma_u, chroma_v
//  out       source     out_valid / out_stall  tl/bl/tr/br x ch0..ch2
//  cfg       sink       cfg_we                 cfg_index, cfg_data (48 bits)
//
// one beat per clock sustained while out_stall is low; the stages are offset
// subtract, multiply, sum and clamp, the 16x16 multipliers having a stage of their own.
// each stage advances when the one after it is empty or moving, so a result
// held by out_stall does not block the stages behind it until all are full.
// reset clears the valid bits and the four registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module yuv420_to_rgb_block (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_we,
    input  wire logic [y2r_pkg::IDX_W-1:0]         cfg_index,
    input  wire logic [y2r_pkg::CFG_W-1:0]         cfg_data,

    input  wire logic                              in_valid,
    output      logic                              in_stall,
    input  wire logic [y2r_pkg::SAMPLE_W-1:0]      luma_top_left,
    input  wire logic [y2r_pkg::SAMPLE_W-1:0]      luma_top_right,
    input  wire logic [y2r_pkg::SAMPLE_W-1:0]      luma_bottom_left,
    input  wire logic [y2r_pkg::SAMPLE_W-1:0]      luma_bottom_right,
    input  wire logic [y2r_pkg::SAMPLE_W-1:0]      chroma_u,
    input  wire logic [y2r_pkg::SAMPLE_W-1:0]      chroma_v,

    output      logic                              out_valid,
    input  wire logic                              out_stall,
    output      logic [y2r_pkg::SAMPLE_W-1:0]      tl_ch0,
    output      logic [y2r_pkg::SAMPLE_W-1:0]      tl_ch1,
    output      logic [y2r_pkg::SAMPLE_W-1:0]      tl_ch2,
    output      logic [y2r_pkg::SAMPLE_W-1:0]      bl_ch0,
    output      logic [y2r_pkg::SAMPLE_W-1:0]      bl_ch1,
    output      logic [y2r_pkg::SAMPLE_W-1:0]      bl_ch2,
    output      logic [y2r_pkg::SAMPLE_W-1:0]      tr_ch0,
    output      logic [y2r_pkg::SAMPLE_W-1:0]      tr_ch1,
    output      logic [y2r_pkg::SAMPLE_W-1:0]      tr_ch2,
    output      logic [y2r_pkg::SAMPLE_W-1:0]      br_ch0,
    output      logic [y2r_pkg::SAMPLE_W-1:0]      br_ch1,
    output      logic [y2r_pkg::SAMPLE_W-1:0]      br_ch2
);

    // configuration
    y2r_pkg::cfg_word_t [y2r_pkg::NUM_CH-1:0] row_reg;
    y2r_pkg::cfg_word_t                       offs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            offs_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (y2r_pkg::reg_idx_t'(cfg_index))
                y2r_pkg::REG_CH0_ROW: row_reg[0] <= cfg_data;
                y2r_pkg::REG_CH1_ROW: row_reg[1] <= cfg_data;
                y2r_pkg::REG_CH2_ROW: row_reg[2] <= cfg_data;
                y2r_pkg::REG_OFFSETS: offs_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage control
    logic s1_vld_reg;
    logic s2_vld_reg;
    logic out_vld_reg;
    logic out_ok;
    logic s2_ok;
    logic s1_ok;
    logic en_in;
    y2r_pkg::stage_ctl_t ctl;

    assign out_ok      = !out_vld_reg || !out_stall;
    assign s2_ok       = !s2_vld_reg || out_ok;
    assign s1_ok       = !s1_vld_reg || s2_ok;
    assign en_in       = in_valid && s1_ok;
    assign ctl.en_prod = s1_vld_reg && s2_ok;
    assign ctl.en_out  = s2_vld_reg && out_ok;
    assign in_stall    = !s1_ok;
    assign out_valid   = out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s1_ok)
            begin
                s1_vld_reg <= in_valid;
            end
            if (s2_ok)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (out_ok)
            begin
                out_vld_reg <= s2_vld_reg;
            end
        end
    end

    // stage 1: offset removal, wraps to 16 bits
    y2r_pkg::pix_t  [y2r_pkg::NUM_PIX-1:0] luma;
    y2r_pkg::coef_t [y2r_pkg::NUM_PIX-1:0] y_diff_reg;
    y2r_pkg::coef_t [y2r_pkg::NUM_PIX-1:0] y_diff_next;
    y2r_pkg::coef_t                        u_diff_reg;
    y2r_pkg::coef_t                        u_diff_next;
    y2r_pkg::coef_t                        v_diff_reg;
    y2r_pkg::coef_t                        v_diff_next;

    // pixel order: top-left, bottom-left, top-right, bottom-right
    assign luma[0] = luma_top_left;
    assign luma[1] = luma_bottom_left;
    assign luma[2] = luma_top_right;
    assign luma[3] = luma_bottom_right;

    always_comb
    begin
        for (int p = 0; p < y2r_pkg::NUM_PIX; p++)
        begin
            y_diff_next[p] = {{(y2r_pkg::COEF_W-y2r_pkg::SAMPLE_W){1'b0}}, luma[p]}
                             - y2r_pkg::field16(offs_reg, y2r_pkg::FLD_Y);
        end
        u_diff_next = {{(y2r_pkg::COEF_W-y2r_pkg::SAMPLE_W){1'b0}}, chroma_u}
                      - y2r_pkg::field16(offs_reg, y2r_pkg::FLD_U);
        v_diff_next = {{(y2r_pkg::COEF_W-y2r_pkg::SAMPLE_W){1'b0}}, chroma_v}
                      - y2r_pkg::field16(offs_reg, y2r_pkg::FLD_V);
    end

    always_ff @(posedge clk)
    begin
        if (en_in)
        begin
            y_diff_reg <= y_diff_next;
            u_diff_reg <= u_diff_next;
            v_diff_reg <= v_diff_next;
        end
    end

    // stage 2: chroma products, shared by all four pixels
    y2r_pkg::prod_t [y2r_pkg::NUM_CH-1:0] u_prod_reg;
    y2r_pkg::prod_t [y2r_pkg::NUM_CH-1:0] u_prod_next;
    y2r_pkg::prod_t [y2r_pkg::NUM_CH-1:0] v_prod_reg;
    y2r_pkg::prod_t [y2r_pkg::NUM_CH-1:0] v_prod_next;

    always_comb
    begin
        for (int c = 0; c < y2r_pkg::NUM_CH; c++)
        begin
            u_prod_next[c] = y2r_pkg::field16(row_reg[c], y2r_pkg::FLD_U) * u_diff_reg;
            v_prod_next[c] = y2r_pkg::field16(row_reg[c], y2r_pkg::FLD_V) * v_diff_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_prod)
        begin
            u_prod_reg <= u_prod_next;
            v_prod_reg <= v_prod_next;
        end
    end

    // per-pixel luma products and output stage
    y2r_pkg::pix_t [y2r_pkg::NUM_PIX-1:0][y2r_pkg::NUM_CH-1:0] pix_ch;

    for (genvar p = 0; p < y2r_pkg::NUM_PIX; p++)
    begin : g_pix
        y2r_pixel u_pixel (
            .clk    (clk),
            .ctl    (ctl),
            .y_diff (y_diff_reg[p]),
            .rows   (row_reg),
            .u_prod (u_prod_reg),
            .v_prod (v_prod_reg),
            .ch     (pix_ch[p])
        );
    end

    assign tl_ch0 = pix_ch[0][0];
    assign tl_ch1 = pix_ch[0][1];
    assign tl_ch2 = pix_ch[0][2];
    assign bl_ch0 = pix_ch[1][0];
    assign bl_ch1 = pix_ch[1][1];
    assign bl_ch2 = pix_ch[1][2];
    assign tr_ch0 = pix_ch[2][0];
    assign tr_ch1 = pix_ch[2][1];
    assign tr_ch2 = pix_ch[2][2];
    assign br_ch0 = pix_ch[3][0];
    assign br_ch1 = pix_ch[3][1];
    assign br_ch2 = pix_ch[3][2];

endmodule

`default_nettype wire
